// ===== design/bs_pkg.sv =====
package bs_pkg;

    localparam int MAX_ELEMENTS = 64;
    localparam int DATA_W       = 32;
    localparam int SIZE_W       = 3;
    // index width of the element store, also the largest usable log2 size
    localparam int IDX_W        = $clog2(MAX_ELEMENTS);
    localparam int LG_W         = $clog2(IDX_W + 1);
    localparam int PAIR_W       = (IDX_W > 1) ? IDX_W - 1 : 1;

    localparam logic [SIZE_W-1:0] SIZE_LOG2_RESET = 3'd6;

    typedef logic signed [DATA_W-1:0] data_t;

endpackage

// ===== design/bs_ram.sv =====
module bs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        // read data holds until the next read
        if (re) begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

// ===== design/bs_cmp.sv =====
module bs_cmp (
    input  bs_pkg::data_t a,
    input  bs_pkg::data_t b,
    input  logic          desc,
    output logic          swap
);
    import bs_pkg::*;

    // ascending pair swaps when lower entry is larger, descending the other way
    always_comb begin
        if (desc) begin
            swap = (b > a);
        end else begin
            swap = (a > b);
        end
    end

endmodule

// ===== design/bitonic_sorter.sv =====
// Bitonic sorter: collects a set of 2^size_log2 signed 32-bit values (size_log2 written through
// the cfg port, clamped to 1..6, reset 6; a write also drops a partly loaded set), sorts them
// in a 64-entry store with a single compare-exchange unit, then returns them smallest first
// with m_last on the final one. Loading accepts one value per cycle. The network then visits
// lg*(lg+1)/2 * N/2 pairs; each pair is read in ST_READ and compared in ST_CMP, which writes
// the lower entry on an exchange, and ST_WRY then writes the upper one, as the store has a single
// write port. Each result is read in ST_EREAD and held in ST_EOUT until the sink is ready.
// No value is taken while a set is sorted or returned.
module bitonic_sorter (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [bs_pkg::SIZE_W-1:0]  cfg_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  bs_pkg::data_t              s_value,
    output logic                       m_valid,
    input  logic                       m_ready,
    output bs_pkg::data_t              m_sorted_value,
    output logic                       m_last
);
    import bs_pkg::*;

    typedef enum logic [5:0] {
        ST_LOAD  = 6'b000001,
        ST_READ  = 6'b000010,
        ST_CMP   = 6'b000100,
        ST_WRY   = 6'b001000,
        ST_EREAD = 6'b010000,
        ST_EOUT  = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [SIZE_W-1:0] size_log2_reg, size_log2_next;
    logic [IDX_W-1:0]  load_count_reg, load_count_next;
    logic [LG_W-1:0]   stage_reg, stage_next;
    logic [LG_W-1:0]   substage_reg, substage_next;
    logic [PAIR_W-1:0] pair_reg, pair_next;
    logic [IDX_W-1:0]  emit_reg, emit_next;

    logic [LG_W-1:0]   lg;
    logic [IDX_W-1:0]  last_idx;
    logic [IDX_W-1:0]  half_last;
    logic [IDX_W-1:0]  j_bit;
    logic [IDX_W-1:0]  j_mask;
    logic [IDX_W-1:0]  pair_ext;
    logic [IDX_W-1:0]  pair_i;
    logic [IDX_W-1:0]  pair_y;
    logic [IDX_W:0]    i_ext;
    logic              desc;
    logic              swap;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    data_t             ram_wdata;
    logic              ram_re;
    logic [IDX_W-1:0]  ram_raddr_a;
    logic [IDX_W-1:0]  ram_raddr_b;
    logic [DATA_W-1:0] ram_rdata_a;
    logic [DATA_W-1:0] ram_rdata_b;

    // effective log2 set size
    always_comb begin
        if (size_log2_reg == '0) begin
            lg = LG_W'(1);
        end else if (size_log2_reg > SIZE_W'(IDX_W)) begin
            lg = LG_W'(IDX_W);
        end else begin
            lg = LG_W'(size_log2_reg);
        end
    end

    assign last_idx  = IDX_W'(((IDX_W + 1)'(1) << lg) - (IDX_W + 1)'(1));
    assign half_last = IDX_W'((IDX_W'(1) << (lg - LG_W'(1))) - IDX_W'(1));

    // lower index of the pair: pair counter with a zero slid in at the partner bit
    assign j_bit    = IDX_W'(1) << substage_reg;
    assign j_mask   = j_bit - IDX_W'(1);
    assign pair_ext = IDX_W'(pair_reg);
    assign pair_i   = IDX_W'({(pair_ext & ~j_mask), 1'b0}) | (pair_ext & j_mask);
    assign pair_y   = pair_i | j_bit;
    assign i_ext    = {1'b0, pair_i};
    assign desc     = i_ext[stage_reg];

    bs_cmp u_cmp (
        .a    (data_t'(ram_rdata_a)),
        .b    (data_t'(ram_rdata_b)),
        .desc (desc),
        .swap (swap)
    );

    bs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_store (
        .clk     (aclk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .re      (ram_re),
        .raddr_a (ram_raddr_a),
        .raddr_b (ram_raddr_b),
        .rdata_a (ram_rdata_a),
        .rdata_b (ram_rdata_b)
    );

    assign cfg_ready      = 1'b1;
    assign s_ready        = (state_reg == ST_LOAD);
    assign m_valid        = (state_reg == ST_EOUT);
    assign m_sorted_value = data_t'(ram_rdata_a);
    assign m_last         = (emit_reg == last_idx);

    always_comb begin
        state_next      = state_reg;
        size_log2_next  = size_log2_reg;
        load_count_next = load_count_reg;
        stage_next      = stage_reg;
        substage_next   = substage_reg;
        pair_next       = pair_reg;
        emit_next       = emit_reg;
        ram_we          = 1'b0;
        ram_waddr       = pair_i;
        ram_wdata       = s_value;
        ram_re          = 1'b0;
        ram_raddr_a     = pair_i;
        ram_raddr_b     = pair_y;

        case (state_reg)
            ST_LOAD: begin
                ram_waddr = load_count_reg;
                if (s_valid) begin
                    ram_we = 1'b1;
                    if (load_count_reg == last_idx) begin
                        load_count_next = '0;
                        stage_next      = LG_W'(1);
                        substage_next   = '0;
                        pair_next       = '0;
                        state_next      = ST_READ;
                    end else begin
                        load_count_next = load_count_reg + IDX_W'(1);
                    end
                end
            end
            ST_READ: begin
                ram_re     = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP, ST_WRY: begin
                if (state_reg == ST_CMP) begin
                    ram_waddr = pair_i;
                    ram_wdata = data_t'(ram_rdata_b);
                    ram_we    = swap;
                end else begin
                    ram_waddr = pair_y;
                    ram_wdata = data_t'(ram_rdata_a);
                    ram_we    = 1'b1;
                end
                if (state_reg == ST_CMP && swap) begin
                    state_next = ST_WRY;
                end else begin
                    state_next = ST_READ;
                    if (pair_ext == half_last) begin
                        pair_next = '0;
                        if (substage_reg == '0) begin
                            if (stage_reg == lg) begin
                                emit_next  = '0;
                                state_next = ST_EREAD;
                            end else begin
                                stage_next    = stage_reg + LG_W'(1);
                                substage_next = stage_reg;
                            end
                        end else begin
                            substage_next = substage_reg - LG_W'(1);
                        end
                    end else begin
                        pair_next = pair_reg + PAIR_W'(1);
                    end
                end
            end
            ST_EREAD: begin
                ram_re      = 1'b1;
                ram_raddr_a = emit_reg;
                state_next  = ST_EOUT;
            end
            ST_EOUT: begin
                if (m_ready) begin
                    if (m_last) begin
                        state_next = ST_LOAD;
                    end else begin
                        emit_next  = emit_reg + IDX_W'(1);
                        state_next = ST_EREAD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase

        // a size write drops any partly loaded set
        if (cfg_valid) begin
            size_log2_next  = cfg_data;
            load_count_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_LOAD;
            size_log2_reg  <= SIZE_LOG2_RESET;
            load_count_reg <= '0;
            stage_reg      <= LG_W'(1);
            substage_reg   <= '0;
            pair_reg       <= '0;
            emit_reg       <= '0;
        end else begin
            state_reg      <= state_next;
            size_log2_reg  <= size_log2_next;
            load_count_reg <= load_count_next;
            stage_reg      <= stage_next;
            substage_reg   <= substage_next;
            pair_reg       <= pair_next;
            emit_reg       <= emit_next;
        end
    end

    a_phases_exclusive: assert property (
        @(posedge aclk) disable iff (!aresetn) m_valid |-> !s_ready
    ) else $error("input accepted while results pending");

    a_back_to_load: assert property (
        @(posedge aclk) disable iff (!aresetn) (m_valid && m_ready && m_last) |=> s_ready
    ) else $error("block did not return to loading after last transfer");

    a_cfg_drops_set: assert property (
        @(posedge aclk) disable iff (!aresetn) (cfg_valid && cfg_ready) |=> load_count_reg == '0
    ) else $error("size write did not drop the partial set");

    a_pair_order: assert property (
        @(posedge aclk) disable iff (!aresetn) (state_reg == ST_CMP) |-> (pair_y > pair_i)
    ) else $error("pair partner not above lower index");

    a_stage_range: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |-> (stage_reg <= lg && substage_reg < stage_reg)
    ) else $error("network counters out of range");

endmodule
